[rtl/rv32i_execute_unit_defines.svh]
// Assertion macros shared by the execute unit checker.
// Standalone header; expects clock and active-low reset names as arguments.
`ifndef RV32I_EXECUTE_UNIT_DEFINES_SVH
`define RV32I_EXECUTE_UNIT_DEFINES_SVH

// same-cycle implication
`define RV_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("execute unit check failed");

// next-cycle implication
`define RV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("execute unit check failed");

`endif

[rtl/rv32ieu_pkg.sv]
// Shared types and constants for the RV32I execute unit.
// No dependencies.
package rv32ieu_pkg;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 136;
    localparam int NUM_REGS    = 32;

    typedef enum logic [5:0] {
        OP_LUI = 6'd0, OP_AUIPC, OP_JAL, OP_JALR,
        OP_BEQ, OP_BNE, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU,
        OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU,
        OP_SB, OP_SH, OP_SW,
        OP_ADD, OP_SUB, OP_SLL, OP_SRL, OP_SLT, OP_SLTU, OP_SRA,
        OP_AND, OP_OR, OP_XOR,
        OP_ADDI, OP_SLTI, OP_SLTIU, OP_XORI, OP_ORI, OP_ANDI,
        OP_SLLI, OP_SRLI, OP_SRAI
    } op_t;

    typedef enum logic [1:0] {
        MEM_BYTE,
        MEM_HALF,
        MEM_WORD
    } mem_size_t;

    // cycle count increments
    localparam logic [1:0] CYC_NONE = 2'd0;
    localparam logic [1:0] CYC_ALU  = 2'd1;
    localparam logic [1:0] CYC_MEM  = 2'd3;

    typedef struct packed {
        logic        ok;
        logic        wr;
        logic [31:0] val;
        logic [31:0] npc;
        logic        is_load;
        logic        is_store;
        mem_size_t   size;
        logic        uns;
        logic [31:0] addr;
        logic [31:0] sdata;
        logic [1:0]  cyc_inc;
    } exec_t;

    typedef struct packed {
        logic        rd_en;
        logic        wr_en;
        mem_size_t   size;
        logic        uns;
        logic [31:0] addr;
        logic [31:0] sdata;
    } dmem_req_t;

endpackage

[rtl/rv32i_execute_unit.sv]
// RV32I execute unit top level: input stage, execute, result stage and state registers.
// Depends on rv32ieu_pkg, rv32ieu_alu, rv32ieu_regfile, rv32ieu_dmem.
// An input beat is registered in the input stage, then its result in the result stage.
// Throughput: one instruction per cycle, stalled by low m_tready or the clear sweep;
// operands and load data forward from the result stage. Reset: pc, cycle count and
// registers read zero; the data store is cleared word by word while s_tready stays low.
module rv32i_execute_unit #(
    parameter int DATA_WORDS = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // action[5:0], dest_reg[10:6], src1_reg[15:11], src2_reg[20:16],
    // immediate_value[52:21], zero pad
    input  logic [rv32ieu_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // next_pc[31:0], reg_written[32], write_index[37:33], write_data[69:38],
    // cycles_so_far[133:70], zero pad
    output logic [rv32ieu_pkg::OUT_TDATA_W-1:0] m_tdata,
    // status[0]
    output logic [0:0]                          m_tuser
);
    import rv32ieu_pkg::*;

    logic        x_valid_reg;
    logic [5:0]  x_action_reg;
    logic [4:0]  x_rd_reg;
    logic [4:0]  x_rs1_reg;
    logic [4:0]  x_rs2_reg;
    logic [31:0] x_imm_reg;

    logic [31:0] pc_reg;
    logic [63:0] cyc_reg;
    logic [63:0] cyc_next;

    logic        w_valid_reg;
    logic        w_status_reg;
    logic [31:0] w_npc_reg;
    logic        w_wr_reg;
    logic [4:0]  w_idx_reg;
    logic [31:0] w_val_reg;
    logic        w_load_reg;
    logic [63:0] w_cyc_reg;

    logic        advance;
    logic        s_accept;
    logic        busy;
    logic [4:0]  raddr_a;
    logic [4:0]  raddr_b;
    logic [31:0] rs1_val;
    logic [31:0] rs2_val;
    exec_t       ex;
    logic        wr_eff;
    dmem_req_t   dreq;
    logic [31:0] ld_data;
    logic [31:0] w_data;

    assign advance  = x_valid_reg && (!w_valid_reg || m_tready);
    assign s_tready = !busy && (!x_valid_reg || advance);
    assign s_accept = s_tvalid && s_tready;

    // RAM copies read the next item's sources, or re-read the held item's
    assign raddr_a = s_accept ? s_tdata[15:11] : x_rs1_reg;
    assign raddr_b = s_accept ? s_tdata[20:16] : x_rs2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_valid_reg <= 1'b0;
            w_valid_reg <= 1'b0;
            pc_reg      <= '0;
            cyc_reg     <= '0;
        end
        else
        begin
            if (s_accept)
            begin
                x_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                x_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                w_valid_reg <= 1'b1;
                pc_reg      <= ex.npc;
                cyc_reg     <= cyc_next;
            end
            else if (m_tready)
            begin
                w_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            x_action_reg <= s_tdata[5:0];
            x_rd_reg     <= s_tdata[10:6];
            x_rs1_reg    <= s_tdata[15:11];
            x_rs2_reg    <= s_tdata[20:16];
            x_imm_reg    <= s_tdata[52:21];
        end
        if (advance)
        begin
            w_status_reg <= !ex.ok;
            w_npc_reg    <= ex.npc;
            w_wr_reg     <= wr_eff;
            w_idx_reg    <= wr_eff ? x_rd_reg : 5'd0;
            w_val_reg    <= wr_eff ? ex.val : 32'd0;
            w_load_reg   <= wr_eff && ex.is_load;
            w_cyc_reg    <= cyc_next;
        end
    end

    rv32ieu_regfile u_regfile (
        .clk     (clk),
        .rst_n   (rst_n),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rs1_idx (x_rs1_reg),
        .rs2_idx (x_rs2_reg),
        .we      (w_valid_reg && w_wr_reg),
        .widx    (w_idx_reg),
        .wdata   (w_data),
        .rs1_val (rs1_val),
        .rs2_val (rs2_val)
    );

    rv32ieu_alu u_alu (
        .action (x_action_reg),
        .imm    (x_imm_reg),
        .pc     (pc_reg),
        .rs1    (rs1_val),
        .rs2    (rs2_val),
        .ex     (ex)
    );

    assign wr_eff   = ex.wr && (x_rd_reg != 5'd0);
    assign cyc_next = cyc_reg + 64'(ex.cyc_inc);

    always_comb
    begin
        dreq.rd_en = advance && ex.is_load;
        dreq.wr_en = advance && ex.is_store;
        dreq.size  = ex.size;
        dreq.uns   = ex.uns;
        dreq.addr  = ex.addr;
        dreq.sdata = ex.sdata;
    end

    rv32ieu_dmem #(.DATA_WORDS(DATA_WORDS)) u_dmem (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (dreq),
        .busy      (busy),
        .load_data (ld_data)
    );

    assign w_data   = w_load_reg ? ld_data : w_val_reg;

    assign m_tvalid = w_valid_reg;
    assign m_tdata  = {2'b00, w_cyc_reg, w_data, w_idx_reg, w_wr_reg, w_npc_reg};
    assign m_tuser  = w_status_reg;

endmodule

[rtl/rv32ieu_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rv32ieu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/rv32ieu_alu.sv]
// Combinational execute logic: ALU, branch compare, jump and address generation.
// Depends on rv32ieu_pkg.
module rv32ieu_alu (
    input  logic [5:0]          action,
    input  logic [31:0]         imm,
    input  logic [31:0]         pc,
    input  logic [31:0]         rs1,
    input  logic [31:0]         rs2,
    output rv32ieu_pkg::exec_t  ex
);
    import rv32ieu_pkg::*;

    logic [31:0] sum;
    logic [31:0] pc_imm;
    logic [31:0] pc4;
    logic        lt_r;
    logic        ltu_r;
    logic        lt_i;
    logic        ltu_i;
    logic [4:0]  sh_r;
    logic [4:0]  sh_i;

    assign sum    = rs1 + imm;
    assign pc_imm = pc + imm;
    assign pc4    = pc + 32'd4;
    assign lt_r   = $signed(rs1) < $signed(rs2);
    assign ltu_r  = rs1 < rs2;
    assign lt_i   = $signed(rs1) < $signed(imm);
    assign ltu_i  = rs1 < imm;
    assign sh_r   = rs2[4:0];
    assign sh_i   = imm[4:0];

    always_comb
    begin
        ex          = '0;
        ex.ok       = 1'b1;
        ex.npc      = pc4;
        ex.addr     = sum;
        ex.sdata    = rs2;
        ex.size     = MEM_WORD;
        ex.cyc_inc  = CYC_ALU;
        case (op_t'(action))
            OP_LUI:   begin ex.wr = 1'b1; ex.val = imm;    end
            OP_AUIPC: begin ex.wr = 1'b1; ex.val = pc_imm; end
            OP_JAL:
            begin
                ex.wr  = 1'b1;
                ex.val = pc4;
                ex.npc = pc_imm;
            end
            OP_JALR:
            begin
                ex.wr  = 1'b1;
                ex.val = pc4;
                ex.npc = {sum[31:1], 1'b0};
            end
            OP_BEQ:  if (rs1 == rs2) ex.npc = pc_imm;
            OP_BNE:  if (rs1 != rs2) ex.npc = pc_imm;
            OP_BLT:  if (lt_r)       ex.npc = pc_imm;
            OP_BGE:  if (!lt_r)      ex.npc = pc_imm;
            OP_BLTU: if (ltu_r)      ex.npc = pc_imm;
            OP_BGEU: if (!ltu_r)     ex.npc = pc_imm;
            OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU:
            begin
                ex.wr      = 1'b1;
                ex.is_load = 1'b1;
                ex.cyc_inc = CYC_MEM;
                ex.uns     = (op_t'(action) == OP_LBU) || (op_t'(action) == OP_LHU);
                if ((op_t'(action) == OP_LB) || (op_t'(action) == OP_LBU))
                begin
                    ex.size = MEM_BYTE;
                end
                else if ((op_t'(action) == OP_LH) || (op_t'(action) == OP_LHU))
                begin
                    ex.size = MEM_HALF;
                end
            end
            OP_SB: begin ex.is_store = 1'b1; ex.cyc_inc = CYC_MEM; ex.size = MEM_BYTE; end
            OP_SH: begin ex.is_store = 1'b1; ex.cyc_inc = CYC_MEM; ex.size = MEM_HALF; end
            OP_SW: begin ex.is_store = 1'b1; ex.cyc_inc = CYC_MEM; end
            OP_ADD:   begin ex.wr = 1'b1; ex.val = rs1 + rs2;                      end
            OP_SUB:   begin ex.wr = 1'b1; ex.val = rs1 - rs2;                      end
            OP_SLL:   begin ex.wr = 1'b1; ex.val = rs1 << sh_r;                    end
            OP_SRL:   begin ex.wr = 1'b1; ex.val = rs1 >> sh_r;                    end
            OP_SLT:   begin ex.wr = 1'b1; ex.val = {31'd0, lt_r};                  end
            OP_SLTU:  begin ex.wr = 1'b1; ex.val = {31'd0, ltu_r};                 end
            OP_SRA:   begin ex.wr = 1'b1; ex.val = 32'($signed(rs1) >>> sh_r);     end
            OP_AND:   begin ex.wr = 1'b1; ex.val = rs1 & rs2;                      end
            OP_OR:    begin ex.wr = 1'b1; ex.val = rs1 | rs2;                      end
            OP_XOR:   begin ex.wr = 1'b1; ex.val = rs1 ^ rs2;                      end
            OP_ADDI:  begin ex.wr = 1'b1; ex.val = sum;                            end
            OP_SLTI:  begin ex.wr = 1'b1; ex.val = {31'd0, lt_i};                  end
            OP_SLTIU: begin ex.wr = 1'b1; ex.val = {31'd0, ltu_i};                 end
            OP_XORI:  begin ex.wr = 1'b1; ex.val = rs1 ^ imm;                      end
            OP_ORI:   begin ex.wr = 1'b1; ex.val = rs1 | imm;                      end
            OP_ANDI:  begin ex.wr = 1'b1; ex.val = rs1 & imm;                      end
            OP_SLLI:  begin ex.wr = 1'b1; ex.val = rs1 << sh_i;                    end
            OP_SRLI:  begin ex.wr = 1'b1; ex.val = rs1 >> sh_i;                    end
            OP_SRAI:  begin ex.wr = 1'b1; ex.val = 32'($signed(rs1) >>> sh_i);     end
            default:
            begin
                // invalid operation: no state change
                ex.ok      = 1'b0;
                ex.npc     = pc;
                ex.cyc_inc = CYC_NONE;
            end
        endcase
    end

endmodule

[rtl/rv32ieu_regfile.sv]
// 32 x 32 register file: two RAM copies for two read ports, valid bits for reset-to-zero,
// and forwarding from the current and the previous write. Depends on rv32ieu_pkg, rv32ieu_ram.
module rv32ieu_regfile (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [4:0]  raddr_a,
    input  logic [4:0]  raddr_b,
    input  logic [4:0]  rs1_idx,
    input  logic [4:0]  rs2_idx,
    input  logic        we,
    input  logic [4:0]  widx,
    input  logic [31:0] wdata,
    output logic [31:0] rs1_val,
    output logic [31:0] rs2_val
);
    import rv32ieu_pkg::*;

    logic [NUM_REGS-1:0] valid_reg;
    logic                last_we_reg;
    logic [4:0]          last_idx_reg;
    logic [31:0]         last_data_reg;
    logic [31:0]         ram_a;
    logic [31:0]         ram_b;

    rv32ieu_ram #(.WIDTH(32), .DEPTH(NUM_REGS)) u_ram_a (
        .clk   (clk),
        .we    (we),
        .waddr (widx),
        .wdata (wdata),
        .re    (1'b1),
        .raddr (raddr_a),
        .rdata (ram_a)
    );

    rv32ieu_ram #(.WIDTH(32), .DEPTH(NUM_REGS)) u_ram_b (
        .clk   (clk),
        .we    (we),
        .waddr (widx),
        .wdata (wdata),
        .re    (1'b1),
        .raddr (raddr_b),
        .rdata (ram_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            last_we_reg <= 1'b0;
        end
        else if (we)
        begin
            valid_reg[widx] <= 1'b1;
            last_we_reg     <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            last_idx_reg  <= widx;
            last_data_reg <= wdata;
        end
    end

    // RAM data lags one write behind; the last write and the pending write cover it
    assign rs1_val = (rs1_idx == 5'd0)                      ? 32'd0 :
                     (we && widx == rs1_idx)                ? wdata :
                     (last_we_reg && last_idx_reg == rs1_idx) ? last_data_reg :
                     valid_reg[rs1_idx]                     ? ram_a : 32'd0;

    assign rs2_val = (rs2_idx == 5'd0)                      ? 32'd0 :
                     (we && widx == rs2_idx)                ? wdata :
                     (last_we_reg && last_idx_reg == rs2_idx) ? last_data_reg :
                     valid_reg[rs2_idx]                     ? ram_b : 32'd0;

endmodule

[rtl/rv32ieu_dmem.sv]
// Byte-lane data store: four 8-bit RAMs, misaligned access across words, clear sweep
// after reset, load alignment and extension. Depends on rv32ieu_pkg, rv32ieu_ram.
module rv32ieu_dmem #(
    parameter int DATA_WORDS = 4096
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rv32ieu_pkg::dmem_req_t req,
    output logic                   busy,
    output logic [31:0]            load_data
);
    import rv32ieu_pkg::*;

    localparam int AW = $clog2(DATA_WORDS);
    localparam bit POW2 = (DATA_WORDS == (1 << AW));
    localparam logic [AW-1:0] LAST = AW'(DATA_WORDS - 1);

    logic            busy_reg;
    logic [AW-1:0]   clr_cnt_reg;
    logic [1:0]      off_reg;
    mem_size_t       size_reg;
    logic            uns_reg;

    logic [29:0]     word_x;
    logic [AW-1:0]   word_base;
    logic [AW-1:0]   word_next;
    logic [1:0]      off;
    logic [63:0]     sdbl;
    logic [31:0]     srot;
    logic [31:0]     lanes;
    logic [63:0]     ldbl;
    logic [31:0]     lrot;
    logic [31:0]     raw;

    assign word_x = req.addr[31:2];
    assign off    = req.addr[1:0];

    generate
        if (POW2)
        begin : g_mask
            assign word_base = word_x[AW-1:0];
        end
        else
        begin : g_recip
            // x mod DATA_WORDS, with floor(x / DATA_WORDS) by reciprocal multiply, exact for 30-bit x
            localparam int MS = 30 + AW;
            localparam logic [63:0] MM =
                ((64'd1 << MS) + 64'(DATA_WORDS) - 64'd1) / 64'(DATA_WORDS);
            logic [61:0] prod;
            logic [29:0] quot;
            logic [29:0] qd;
            logic [29:0] rem;
            assign prod = 62'(word_x) * 62'(MM[31:0]);
            assign quot = 30'(prod >> MS);
            assign qd   = 30'(quot * 30'(DATA_WORDS));
            assign rem  = word_x - qd;
            assign word_base = rem[AW-1:0];
        end
    endgenerate

    assign word_next = (word_x == 30'h3FFF_FFFF) ? '0 :
                       (word_base == LAST)       ? '0 : word_base + AW'(1);

    // store bytes rotated onto lanes
    assign sdbl = {req.sdata, req.sdata} << {off, 3'b000};
    assign srot = sdbl[63:32];

    genvar gl;
    generate
        for (gl = 0; gl < 4; gl++)
        begin : g_lane
            logic [1:0]    k;
            logic          en;
            logic [AW-1:0] waddr;
            logic [AW-1:0] addr;
            logic [7:0]    wdata;
            logic          we;

            assign k     = 2'(gl) - off;
            assign en    = (req.size == MEM_WORD) ||
                           (req.size == MEM_HALF && !k[1]) ||
                           (k == 2'd0);
            assign addr  = (2'(gl) < off) ? word_next : word_base;
            assign we    = busy_reg || (req.wr_en && en);
            assign waddr = busy_reg ? clr_cnt_reg : addr;
            assign wdata = busy_reg ? 8'd0 : srot[8*gl +: 8];

            rv32ieu_ram #(.WIDTH(8), .DEPTH(DATA_WORDS)) u_ram (
                .clk   (clk),
                .we    (we),
                .waddr (waddr),
                .wdata (wdata),
                .re    (req.rd_en),
                .raddr (addr),
                .rdata (lanes[8*gl +: 8])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b1;
            clr_cnt_reg <= '0;
        end
        else if (busy_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
            if (clr_cnt_reg == LAST)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            off_reg  <= off;
            size_reg <= req.size;
            uns_reg  <= req.uns;
        end
    end

    assign ldbl = {lanes, lanes} >> {off_reg, 3'b000};
    assign lrot = ldbl[31:0];

    always_comb
    begin
        case (size_reg)
            MEM_BYTE: raw = {{24{lrot[7] & ~uns_reg}}, lrot[7:0]};
            MEM_HALF: raw = {{16{lrot[15] & ~uns_reg}}, lrot[15:0]};
            MEM_WORD: raw = lrot;
            default:  raw = lrot;
        endcase
    end

    assign load_data = raw;
    assign busy      = busy_reg;

endmodule

[rtl/rv32ieu_checker.sv]
// Port-level checks on the execute unit result stream, bound to the top level.
// Depends on rv32ieu_pkg and rv32i_execute_unit_defines.svh.
`include "rv32i_execute_unit_defines.svh"

module rv32ieu_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [rv32ieu_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic [0:0]                          m_tuser
);
    import rv32ieu_pkg::*;

    logic                 wb;
    logic [4:0]           wb_idx;
    logic [31:0]          wb_data;
    logic [OUT_TDATA_W:0] out_beat;

    assign wb       = m_tdata[32];
    assign wb_idx   = m_tdata[37:33];
    assign wb_data  = m_tdata[69:38];
    assign out_beat = {m_tuser, m_tdata};

    // invalid instruction never writes back
    `RV_ASSERT_IMP(a_invalid_no_wb, clk, rst_n, m_tvalid && m_tuser[0], !wb && wb_data == 32'd0)

    // no write-back reports zero index and data
    `RV_ASSERT_IMP(a_no_wb_zero, clk, rst_n, m_tvalid && !wb, wb_idx == 5'd0 && wb_data == 32'd0)

    // x0 is never reported as written
    `RV_ASSERT_IMP(a_wb_not_x0, clk, rst_n, m_tvalid && wb, wb_idx != 5'd0)

    // a stalled beat holds
    `RV_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(out_beat))

endmodule

bind rv32i_execute_unit rv32ieu_checker u_checker (.*);
